// ===== rtl/irc_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types, constants and helpers for the integer to ASCII radix core.
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int VALUE_W        = 64;
  localparam int HALF_W         = VALUE_W / 2;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int CMD_W          = 3;
  localparam int BIT_CNT_W      = $clog2(VALUE_W);
  localparam int DEF_MAX_DIGITS = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_UDEC = 3'd0,
    CMD_OCT  = 3'd1,
    CMD_HEX  = 3'd2,
    CMD_SDEC = 3'd3,
    CMD_PTR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_DIGIT
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               wide;
  } req_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } txt_beat_t;

  typedef struct packed {
    logic load;
    logic shift_bit;
    logic shift_digit;
  } dp_ctrl_t;

  typedef struct packed {
    logic              push;
    logic [CHAR_W-1:0] character;
    logic              last;
  } emit_t;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

  localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return HEX_CHARS[d];
  endfunction

  function automatic logic cmd_known(input logic [CMD_W-1:0] c);
    return (c == CMD_UDEC) || (c == CMD_OCT) || (c == CMD_HEX) ||
           (c == CMD_SDEC) || (c == CMD_PTR);
  endfunction

endpackage

// ===== rtl/irc_digit_sr.sv =====
// ----------------------------------------------------------------------------
// irc_digit_sr
// Value shift register and digit chain. The value shifts in one bit per
// cycle, msb first; decimal digits get the add-3 correction on the way.
// ----------------------------------------------------------------------------
module irc_digit_sr
  import irc_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic               clk,
  input  dp_ctrl_t           dp,
  input  req_beat_t          req,
  output logic [DIGIT_W-1:0] top_digit
);

  logic [VALUE_W-1:0] value_sr;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  radix_e             radix;

  logic [VALUE_W-1:0] ext;
  logic [VALUE_W-1:0] mag;
  logic               sign_fill;
  radix_e             radix_next;
  logic [DIGIT_W-1:0] adj       [MAX_DIGITS];
  logic [DIGIT_W-1:0] conv_next [MAX_DIGITS];
  logic [MAX_DIGITS:0] carry;

  // operand prep: narrow extension and magnitude of negative signed values
  always_comb begin
    sign_fill = (req.cmd == CMD_SDEC) && req.value[HALF_W-1];
    ext       = req.value;
    if ((req.cmd != CMD_PTR) && !req.wide) begin
      ext = {{HALF_W{sign_fill}}, req.value[HALF_W-1:0]};
    end
    mag = ext;
    if ((req.cmd == CMD_SDEC) && ext[VALUE_W-1]) begin
      mag = ~ext + VALUE_W'(1);
    end
    priority if (req.cmd == CMD_OCT) begin
      radix_next = RADIX_OCT;
    end else if ((req.cmd == CMD_HEX) || (req.cmd == CMD_PTR)) begin
      radix_next = RADIX_HEX;
    end else begin
      radix_next = RADIX_DEC;
    end
  end

  // one bit shift through the digit chain
  always_comb begin
    carry[0] = value_sr[VALUE_W-1];
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = digits[i];
      if ((radix == RADIX_DEC) && (digits[i] >= DIGIT_W'(5))) begin
        adj[i] = digits[i] + DIGIT_W'(3);
      end
      if (radix == RADIX_OCT) begin
        conv_next[i] = {1'b0, digits[i][1:0], carry[i]};
        carry[i+1]   = digits[i][2];
      end else begin
        conv_next[i] = {adj[i][DIGIT_W-2:0], carry[i]};
        carry[i+1]   = adj[i][DIGIT_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp.load) begin
      value_sr <= mag;
      radix    <= radix_next;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (dp.shift_bit) begin
      value_sr <= {value_sr[VALUE_W-2:0], 1'b0};
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= conv_next[i];
      end
    end else if (dp.shift_digit) begin
      digits[0] <= '0;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits[i] <= digits[i-1];
      end
    end
  end

  assign top_digit = digits[MAX_DIGITS-1];

endmodule

// ===== rtl/irc_ctrl.sv =====
// ----------------------------------------------------------------------------
// irc_ctrl
// Sequencer: load, 64 conversion shifts, leading zero skip, prefix and
// digit emission with the last flag.
// ----------------------------------------------------------------------------
module irc_ctrl
  import irc_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_beat_t          req,
  input  logic               emit_ok,
  input  logic [DIGIT_W-1:0] top_digit,
  output dp_ctrl_t           dp,
  output emit_t              emit
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  state_e               state;
  state_e               state_next;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     remaining;
  logic                 neg;
  logic                 ptr;

  logic req_take;
  logic req_neg;
  logic top_zero;
  logic rem_one;

  assign req_ready = (state == ST_IDLE);
  assign req_take  = req_valid && req_ready && cmd_known(req.cmd);
  assign req_neg   = (req.cmd == CMD_SDEC) &&
                     (req.wide ? req.value[VALUE_W-1] : req.value[HALF_W-1]);
  assign top_zero  = (top_digit == '0);
  assign rem_one   = (remaining == CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(top_zero && !rem_one)) begin
          priority if (neg) begin
            state_next = ST_SIGN;
          end else if (ptr) begin
            state_next = ST_PFX_ZERO;
          end else begin
            state_next = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (emit_ok) begin
          state_next = ST_DIGIT;
        end
      end
      ST_PFX_ZERO: begin
        if (emit_ok) begin
          state_next = ST_PFX_X;
        end
      end
      ST_PFX_X: begin
        if (emit_ok) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (emit_ok && rem_one) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dp             = '0;
    emit           = '0;
    emit.character = digit_char(top_digit);
    unique case (state)
      ST_IDLE: begin
        dp.load = req_take;
      end
      ST_CONV: begin
        dp.shift_bit = 1'b1;
      end
      ST_SKIP: begin
        dp.shift_digit = top_zero && !rem_one;
      end
      ST_SIGN: begin
        emit.push      = emit_ok;
        emit.character = CHAR_MINUS;
      end
      ST_PFX_ZERO: begin
        emit.push      = emit_ok;
        emit.character = CHAR_ZERO;
      end
      ST_PFX_X: begin
        emit.push      = emit_ok;
        emit.character = CHAR_X;
      end
      ST_DIGIT: begin
        emit.push      = emit_ok;
        emit.last      = rem_one;
        dp.shift_digit = emit_ok;
      end
      default: begin
        dp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      remaining <= '0;
      neg       <= 1'b0;
      ptr       <= 1'b0;
    end else begin
      state <= state_next;
      if (dp.load) begin
        bit_cnt   <= '0;
        remaining <= CNT_W'(MAX_DIGITS);
        neg       <= req_neg;
        ptr       <= (req.cmd == CMD_PTR);
      end else begin
        if (dp.shift_bit) begin
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        end
        if (dp.shift_digit) begin
          remaining <= remaining - CNT_W'(1);
        end
      end
    end
  end

  a_one_shift_kind: assert property (@(posedge clk) disable iff (rst)
    !(dp.shift_bit && dp.shift_digit) && !(dp.load && (dp.shift_bit || dp.shift_digit)))
    else $error("datapath given conflicting commands");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit.push |-> emit_ok)
    else $error("character pushed into a full output stage");

  a_conv_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP && $past(state) == ST_CONV) |->
      $past(bit_cnt) == BIT_CNT_W'(VALUE_W - 1))
    else $error("conversion left before all value bits shifted in");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_SIGN || state == ST_PFX_ZERO ||
     state == ST_PFX_X || state == ST_DIGIT) |-> remaining != '0)
    else $error("digit counter ran out before the last character");

endmodule

// ===== rtl/irc_out_stage.sv =====
// ----------------------------------------------------------------------------
// irc_out_stage
// Output register for character beats; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module irc_out_stage
  import irc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_t     emit,
  output logic      emit_ok,
  output logic      txt_valid,
  input  logic      txt_ready,
  output txt_beat_t txt_beat
);

  assign emit_ok = !txt_valid || txt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid <= 1'b0;
    end else if (emit_ok) begin
      txt_valid <= emit.push;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push && emit_ok) begin
      txt_beat.character <= emit.character;
      txt_beat.last      <= emit.last;
    end
  end

endmodule

// ===== rtl/integer_to_ascii_radix_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts one integer to its ASCII text (decimal, octal, hex, signed
// decimal or 0x pointer), one character beat at a time, msd first.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_beat  (cmd, value, wide)
//   txt      out  txt_valid/txt_ready   txt_beat  (character, last)
//
// a value is loaded, converted bit-serially through the value shift register,
// then leading zeros are skipped, then the characters are emitted as txt takes them
// the conversion length is set by the value shift register width, one bit per cycle
// req_ready is high only while idle; an unknown cmd is taken and dropped
// txt stalls hold the sequencer; the next req is taken as the last
// character sits in the output register
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core
  import irc_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_beat_t req_beat,
  output logic      txt_valid,
  input  logic      txt_ready,
  output txt_beat_t txt_beat
);

  dp_ctrl_t           dp;
  emit_t              emit;
  logic               emit_ok;
  logic [DIGIT_W-1:0] top_digit;

  irc_ctrl #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_beat),
    .emit_ok   (emit_ok),
    .top_digit (top_digit),
    .dp        (dp),
    .emit      (emit)
  );

  irc_digit_sr #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_sr (
    .clk       (clk),
    .dp        (dp),
    .req       (req_beat),
    .top_digit (top_digit)
  );

  irc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .emit_ok   (emit_ok),
    .txt_valid (txt_valid),
    .txt_ready (txt_ready),
    .txt_beat  (txt_beat)
  );

endmodule
